// ----- rtl/sorted_priority_queue_top_assert.svh -----
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define SPQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("sorted priority queue assertion failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define SPQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sorted priority queue assertion failed");

`endif

// ----- rtl/spq_pkg.sv -----
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned PrioW = 16;
  localparam int unsigned OutCntW = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Command broadcast to every cell at once.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_cmd_t;

  // Status a cell shows to its right-hand neighbor.
  typedef struct packed {
    logic gt;
    logic occ;
  } link_t;

endpackage

// ----- rtl/spq_in_if.sv -----
// Input channel of the sorted priority queue.
interface spq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic signed [spq_pkg::DataW-1:0] data_value;
  logic signed [spq_pkg::PrioW-1:0] priority_value;

  modport source (output valid, opcode, data_value, priority_value, input ready);
  modport sink (input valid, opcode, data_value, priority_value, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// Result channel of the sorted priority queue.
interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [spq_pkg::DataW-1:0]  removed_data;
  logic signed [spq_pkg::PrioW-1:0]  removed_priority;
  logic [spq_pkg::OutCntW-1:0]       entry_count;

  modport source (output valid, status, removed_data, removed_priority, entry_count,
                  input ready);
  modport sink (input valid, status, removed_data, removed_priority, entry_count,
                output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  logic               occ_i,
  input  spq_pkg::link_t     left_i,
  input  spq_pkg::entry_t    left_entry_i,
  input  spq_pkg::entry_t    right_entry_i,
  output logic               gt_o,
  output spq_pkg::entry_t    entry_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            gt;

  assign gt = occ_i && ($signed(entry_q.prio) > $signed(cmd_i.new_entry.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      // Entries with a larger priority move one place toward the tail; the
      // first such slot, or the first free slot, takes the new entry.
      if (left_i.gt) begin
        entry_d = left_entry_i;
      end else if (gt || (!occ_i && left_i.occ)) begin
        entry_d = cmd_i.new_entry;
      end
    end else if (cmd_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign gt_o    = gt;
  assign entry_o = entry_q;

endmodule

// ----- rtl/sorted_priority_queue_top.sv -----
// Sorted priority queue: a chain of Depth cells kept in priority order.
//
// Input channel in_i carries an opcode (insert or remove), a data word and a
// signed priority; result channel out_o carries status, the removed entry and
// the entry count after the operation. Both use valid/ready, and a
// transaction completes when both are high at a rising clock edge.
// An insert goes behind every stored entry of lower or equal priority; a
// remove returns the head, the entry of the smallest priority.
// Every cell compares its priority with the new one in parallel and moves its
// entry one place along the chain. The result appears in the output register
// the cycle after the input transaction, and the block takes one item per
// cycle while the receiver does not stall out_o.
// Inserts on a full queue report full; removes on an empty queue report
// underflow, and the queue is left as it was.
// Reset empties the queue at once: the entry count is cleared, stored entries
// are not. While the receiver holds out_o ready low with a result waiting, the
// input is not accepted; the result register alone parts the two sides.
module sorted_priority_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  `include "sorted_priority_queue_top_assert.svh"

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CntW;

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  spq_pkg::status_e    status_q, status_d;
  spq_pkg::entry_t     rem_q, rem_d;
  logic [spq_pkg::OutCntW-1:0] out_cnt_q;

  logic                accept, is_insert, full, empty;
  spq_pkg::cell_cmd_t  cmd;
  logic            [Depth-1:0] occ, gt;
  spq_pkg::entry_t [Depth-1:0] entries;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_insert  = (spq_pkg::opcode_e'(in_i.opcode) == spq_pkg::OP_INSERT);
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);

  assign cmd.insert         = accept && is_insert && !full;
  assign cmd.remove         = accept && !is_insert && !empty;
  assign cmd.new_entry.data = in_i.data_value;
  assign cmd.new_entry.prio = in_i.priority_value;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::link_t  left;
    spq_pkg::entry_t left_entry, right_entry;

    assign occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left.gt     = 1'b0;
      assign left.occ    = 1'b1;
      assign left_entry  = '0;
    end else begin : g_body
      assign left.gt     = gt[i-1];
      assign left.occ    = occ[i-1];
      assign left_entry  = entries[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_i       (left),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .gt_o         (gt[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    rem_d    = '0;
    status_d = spq_pkg::ST_INSERTED;
    if (is_insert) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (empty) begin
      status_d = spq_pkg::ST_UNDERFLOW;
    end else begin
      status_d = spq_pkg::ST_REMOVED;
      rem_d    = entries[0];
      count_d  = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rem_q     <= rem_d;
      out_cnt_q <= spq_pkg::OutCntW'(count_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = status_q;
  assign out_o.removed_data     = rem_q.data;
  assign out_o.removed_priority = rem_q.prio;
  assign out_o.entry_count      = out_cnt_q;

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth))
  `SPQ_ASSERT_NEXT(a_full_reject, clk_i, rst_ni, accept && is_insert && full,
                   out_valid_q && status_q == spq_pkg::ST_FULL && count_q == $past(count_q))
  `SPQ_ASSERT_NEXT(a_remove_count, clk_i, rst_ni, accept && !is_insert && !empty,
                   count_q == $past(count_q) - CntW'(1))
  `SPQ_ASSERT(a_zero_payload, clk_i, rst_ni,
              !out_valid_q || status_q == spq_pkg::ST_REMOVED || rem_q == '0)

endmodule
